// File: rtl/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation block.
// No dependencies; imported by every module of the block.
package qvr_pkg;

    // Configuration port geometry: four registers, 4 bytes apart.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_LSB = 2;

    // Register map, in word order.
    typedef enum logic [1:0] {
        REG_ROT_REAL = 2'd0,
        REG_ROT_I    = 2'd1,
        REG_ROT_J    = 2'd2,
        REG_ROT_K    = 2'd3
    } t_reg_idx;

endpackage

// File: rtl/quaternion_vector_rotation.sv
// Quaternion vector rotation: top level with register file and four-stage pipeline.
// Depends on qvr_pkg, qvr_mul and qvr_sum.
//
// Rotates each input vector (x, y, z) by the configured quaternion r as
// r * v * conj(r) and returns the i, j, k parts; all components are signed
// fixed point, COMPONENT_WIDTH bits with FRACTION_BITS fraction bits. One word
// is taken every cycle while o_stall is low, and each result passes the stages
// in order (product bank, sum, product bank, sum, the last sum stage being the
// output register). Each stage is a valid/stall stage that fills bubbles, so a
// stall at the output holds only the stages that are full. The first product
// p = r * v is rounded to nearest (half up) and saturated to two extra integer
// bits; the final components are rounded the same way and saturated to the
// component range. Write the rotation registers (rot_real at 0x0, rot_i 0x4,
// rot_j 0x8, rot_k 0xC) only while the pipeline is empty; rot_real resets to
// 1.0 and the others to zero, so the block passes vectors through after reset.
module quaternion_vector_rotation #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 14
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qvr_pkg::PADDR_W-1:0]          paddr,
    input  logic [qvr_pkg::PDATA_W-1:0]          pwdata,
    output logic [qvr_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    // input vector words
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [COMPONENT_WIDTH-1:0]    i_vec_x,
    input  logic signed [COMPONENT_WIDTH-1:0]    i_vec_y,
    input  logic signed [COMPONENT_WIDTH-1:0]    i_vec_z,
    // rotated vector words
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [COMPONENT_WIDTH-1:0]    o_out_x,
    output logic signed [COMPONENT_WIDTH-1:0]    o_out_y,
    output logic signed [COMPONENT_WIDTH-1:0]    o_out_z
);
    import qvr_pkg::*;

    localparam int W  = COMPONENT_WIDTH;
    localparam int PW = COMPONENT_WIDTH + 2;   // width of intermediate p

    // 1.0 in the component format, clipped where it does not fit.
    localparam logic [W-1:0] ROT_REAL_RST = (FRACTION_BITS >= W - 1) ?
        {1'b0, {(W-1){1'b1}}} : ({{(W-1){1'b0}}, 1'b1} << FRACTION_BITS);

    // Sign of each term. First sum: groups pr, pi, pj, pk of three terms.
    localparam logic [11:0] NEG_A = 12'b100_010_100_111;
    // Second sum: groups qi, qj, qk of four terms.
    localparam logic [11:0] NEG_B = 12'b0011_1001_0101;

    // ------------------------------------------------------------------
    // Rotation registers
    // ------------------------------------------------------------------
    logic signed [W-1:0] r_rot_real;
    logic signed [W-1:0] r_rot_i;
    logic signed [W-1:0] r_rot_j;
    logic signed [W-1:0] r_rot_k;
    logic                cfg_wr;
    t_reg_idx            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[REG_LSB +: 2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_real <= ROT_REAL_RST;
            r_rot_i    <= '0;
            r_rot_j    <= '0;
            r_rot_k    <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ROT_REAL: r_rot_real <= pwdata[W-1:0];
                REG_ROT_I:    r_rot_i    <= pwdata[W-1:0];
                REG_ROT_J:    r_rot_j    <= pwdata[W-1:0];
                REG_ROT_K:    r_rot_k    <= pwdata[W-1:0];
                default:      r_rot_real <= r_rot_real;
            endcase
        end
    end

    // Read back sign-extended to the bus width.
    always_comb begin
        unique case (cfg_idx)
            REG_ROT_REAL: prdata = PDATA_W'(r_rot_real);
            REG_ROT_I:    prdata = PDATA_W'(r_rot_i);
            REG_ROT_J:    prdata = PDATA_W'(r_rot_j);
            REG_ROT_K:    prdata = PDATA_W'(r_rot_k);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 1: products of r and v
    // ------------------------------------------------------------------
    logic signed [W-1:0]     mul_a_a [12];
    logic signed [W-1:0]     mul_a_b [12];
    logic signed [2*W-1:0]   prod_a  [12];
    logic                    prod_a_valid;
    logic                    prod_a_stall;

    // pr = -(ri x + rj y + rk z)
    assign mul_a_a[0]  = r_rot_i;    assign mul_a_b[0]  = i_vec_x;
    assign mul_a_a[1]  = r_rot_j;    assign mul_a_b[1]  = i_vec_y;
    assign mul_a_a[2]  = r_rot_k;    assign mul_a_b[2]  = i_vec_z;
    // pi = rr x + rj z - rk y
    assign mul_a_a[3]  = r_rot_real; assign mul_a_b[3]  = i_vec_x;
    assign mul_a_a[4]  = r_rot_j;    assign mul_a_b[4]  = i_vec_z;
    assign mul_a_a[5]  = r_rot_k;    assign mul_a_b[5]  = i_vec_y;
    // pj = rr y - ri z + rk x
    assign mul_a_a[6]  = r_rot_real; assign mul_a_b[6]  = i_vec_y;
    assign mul_a_a[7]  = r_rot_i;    assign mul_a_b[7]  = i_vec_z;
    assign mul_a_a[8]  = r_rot_k;    assign mul_a_b[8]  = i_vec_x;
    // pk = rr z + ri y - rj x
    assign mul_a_a[9]  = r_rot_real; assign mul_a_b[9]  = i_vec_z;
    assign mul_a_a[10] = r_rot_i;    assign mul_a_b[10] = i_vec_y;
    assign mul_a_a[11] = r_rot_j;    assign mul_a_b[11] = i_vec_x;

    qvr_mul #(.AW(W), .BW(W), .N(12)) u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_a     (mul_a_a),
        .i_b     (mul_a_b),
        .o_valid (prod_a_valid),
        .i_stall (prod_a_stall),
        .o_prod  (prod_a)
    );

    // ------------------------------------------------------------------
    // Stage 2: p = r * v, rounded and saturated to PW bits
    // ------------------------------------------------------------------
    logic signed [PW-1:0] p_q [4];
    logic                 p_valid;
    logic                 p_stall;

    qvr_sum #(
        .PW(2*W), .NG(4), .NT(3), .NEG(NEG_A), .FB(FRACTION_BITS), .OW(PW)
    ) u_sum_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_a_valid),
        .o_stall (prod_a_stall),
        .i_prod  (prod_a),
        .o_valid (p_valid),
        .i_stall (p_stall),
        .o_sum   (p_q)
    );

    // ------------------------------------------------------------------
    // Stage 3: products of p and conj(r)
    // ------------------------------------------------------------------
    logic signed [PW-1:0]     mul_b_a [12];
    logic signed [W-1:0]      mul_b_b [12];
    logic signed [PW+W-1:0]   prod_b  [12];
    logic                     prod_b_valid;
    logic                     prod_b_stall;

    // qi = -pr ri + pi rr - pj rk + pk rj
    assign mul_b_a[0]  = p_q[0]; assign mul_b_b[0]  = r_rot_i;
    assign mul_b_a[1]  = p_q[1]; assign mul_b_b[1]  = r_rot_real;
    assign mul_b_a[2]  = p_q[2]; assign mul_b_b[2]  = r_rot_k;
    assign mul_b_a[3]  = p_q[3]; assign mul_b_b[3]  = r_rot_j;
    // qj = -pr rj + pi rk + pj rr - pk ri
    assign mul_b_a[4]  = p_q[0]; assign mul_b_b[4]  = r_rot_j;
    assign mul_b_a[5]  = p_q[1]; assign mul_b_b[5]  = r_rot_k;
    assign mul_b_a[6]  = p_q[2]; assign mul_b_b[6]  = r_rot_real;
    assign mul_b_a[7]  = p_q[3]; assign mul_b_b[7]  = r_rot_i;
    // qk = -pr rk - pi rj + pj ri + pk rr
    assign mul_b_a[8]  = p_q[0]; assign mul_b_b[8]  = r_rot_k;
    assign mul_b_a[9]  = p_q[1]; assign mul_b_b[9]  = r_rot_j;
    assign mul_b_a[10] = p_q[2]; assign mul_b_b[10] = r_rot_i;
    assign mul_b_a[11] = p_q[3]; assign mul_b_b[11] = r_rot_real;

    qvr_mul #(.AW(PW), .BW(W), .N(12)) u_mul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_valid),
        .o_stall (p_stall),
        .i_a     (mul_b_a),
        .i_b     (mul_b_b),
        .o_valid (prod_b_valid),
        .i_stall (prod_b_stall),
        .o_prod  (prod_b)
    );

    // ------------------------------------------------------------------
    // Stage 4: vector part of p * conj(r); this stage is the output register
    // ------------------------------------------------------------------
    logic signed [W-1:0] q_q [3];

    qvr_sum #(
        .PW(PW+W), .NG(3), .NT(4), .NEG(NEG_B), .FB(FRACTION_BITS), .OW(W)
    ) u_sum_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_b_valid),
        .o_stall (prod_b_stall),
        .i_prod  (prod_b),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_sum   (q_q)
    );

    assign o_out_x = q_q[0];
    assign o_out_y = q_q[1];
    assign o_out_z = q_q[2];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Without downstream backpressure the pipeline never pushes back.
    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output side is free");

    // An accepted word reaches the output while the receiver does not stall.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("accepted word did not reach the output in time");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

// File: rtl/qvr_mul.sv
// Registered multiplier bank: N independent signed products per word.
// Depends on qvr_pkg.
module qvr_mul #(
    parameter int AW = 16,
    parameter int BW = 16,
    parameter int N  = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [AW-1:0]        i_a [N],
    input  logic signed [BW-1:0]        i_b [N],
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [AW+BW-1:0]     o_prod [N]
);
    import qvr_pkg::*;

    logic                     r_valid;
    logic                     n_valid;
    logic signed [AW+BW-1:0]  r_prod [N];
    logic                     load;

    // Hold only while a word sits here and the next stage refuses it.
    assign o_stall = r_valid && i_stall;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (!o_stall) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int n = 0; n < N; n++) begin
                r_prod[n] <= i_a[n] * i_b[n];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

// File: rtl/qvr_sum.sv
// Registered signed sum of product groups with round-to-nearest and saturation.
// Depends on qvr_pkg.
module qvr_sum #(
    parameter int                 PW  = 32,
    parameter int                 NG  = 4,
    parameter int                 NT  = 3,
    parameter logic [NG*NT-1:0]   NEG = '0,
    parameter int                 FB  = 14,
    parameter int                 OW  = 18
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [PW-1:0]    i_prod [NG*NT],
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OW-1:0]    o_sum [NG]
);
    import qvr_pkg::*;

    // Room for NT terms, their negation and the rounding constant.
    localparam int SW = (PW + 3 > FB + 1) ? PW + 3 : FB + 2;
    localparam logic [SW-1:0] HALF    = {{(SW-1){1'b0}}, 1'b1} << (FB - 1);
    localparam logic [SW-1:0] SAT_MAX = {{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic [SW-1:0] SAT_MIN = {{(SW-OW+1){1'b1}}, {(OW-1){1'b0}}};

    logic                   r_valid;
    logic                   n_valid;
    logic signed [OW-1:0]   r_sum [NG];
    logic signed [OW-1:0]   n_sum [NG];
    logic                   load;

    assign o_stall = r_valid && i_stall;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (!o_stall) begin
            n_valid = i_valid;
        end
    end

    always_comb begin
        logic signed [SW-1:0] acc;
        logic signed [SW-1:0] term;
        logic signed [SW-1:0] rnd;
        for (int g = 0; g < NG; g++) begin
            acc = '0;
            for (int t = 0; t < NT; t++) begin
                term = SW'(i_prod[g*NT+t]);
                if (NEG[g*NT+t]) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            // Round half up: add half an LSB, then floor.
            rnd = (acc + $signed(HALF)) >>> FB;
            if (rnd > $signed(SAT_MAX)) begin
                n_sum[g] = OW'(SAT_MAX);
            end else if (rnd < $signed(SAT_MIN)) begin
                n_sum[g] = OW'(SAT_MIN);
            end else begin
                n_sum[g] = OW'(rnd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_sum   = r_sum;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for quaternion_vector_rotation: directed table, then random phases.
// Depends on qvr_pkg and the RTL of the block; predicts each rotated word with a local
// fixed-point model and checks it against the output stream in order.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qvr_pkg::*;

    localparam int W               = 16;
    localparam int FRAC            = 14;
    localparam int RAND_PHASES     = 6;
    localparam int WORDS_PER_PHASE = 250;
    localparam int HOLD_CYCLES     = 64;
    localparam int IDLE_LIMIT      = 1000;

    // One vector word: x, y, z as raw Q2.14 bit patterns.
    typedef struct packed {
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic [W-1:0] z;
    } t_vec3;

    // Directed rows: load a rotation, send a vector checked by the model, or send a
    // vector whose result is typed in the row.
    typedef enum logic [1:0] {
        ROW_ROT,
        ROW_VEC,
        ROW_VEC_KNOWN
    } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        int        a;
        int        b;
        int        c;
        int        d;
        int        ex;
        int        ey;
        int        ez;
    } t_dir_row;

    localparam int N_DIR = 30;

    t_dir_row dir_rows [N_DIR] = '{
        // reset rotation is 1.0: every vector, extremes included, passes through
        '{ROW_VEC_KNOWN,      0,      0,      0, 0,      0,      0,      0},
        '{ROW_VEC_KNOWN,  32767,  32767,  32767, 0,  32767,  32767,  32767},
        '{ROW_VEC_KNOWN, -32768, -32768, -32768, 0, -32768, -32768, -32768},
        '{ROW_VEC_KNOWN,  32767, -32768,      1, 0,  32767, -32768,      1},
        '{ROW_VEC_KNOWN,     -1,  16384, -16384, 0,     -1,  16384, -16384},
        // zero rotation wipes out every vector
        '{ROW_ROT,            0,      0,      0, 0,      0,      0,      0},
        '{ROW_VEC_KNOWN,  32767, -32768,  12345, 0,      0,      0,      0},
        // quarter turn about z
        '{ROW_ROT,        11585,      0,      0, 11585,  0,      0,      0},
        '{ROW_VEC,        16384,      0,      0, 0,      0,      0,      0},
        '{ROW_VEC,            0,  16384,      0, 0,      0,      0,      0},
        '{ROW_VEC,            0,      0,  16384, 0,      0,      0,      0},
        '{ROW_VEC,       -32768,  32767, -32768, 0,      0,      0,      0},
        // third of a turn about the diagonal, exact in Q2.14
        '{ROW_ROT,         8192,   8192,   8192, 8192,   0,      0,      0},
        '{ROW_VEC,        16384,      0,      0, 0,      0,      0,      0},
        '{ROW_VEC,            1,      2,      3, 0,      0,      0,      0},
        '{ROW_VEC,        32767, -32768,  32767, 0,      0,      0,      0},
        // far from unit: intermediate product and output both saturate
        '{ROW_ROT,        32767,  32767,  32767, 32767,  0,      0,      0},
        '{ROW_VEC,        32767,  32767,  32767, 0,      0,      0,      0},
        '{ROW_VEC,       -32768,  32767, -32768, 0,      0,      0,      0},
        '{ROW_VEC,          100,   -100,     50, 0,      0,      0,      0},
        '{ROW_ROT,       -32768, -32768, -32768, -32768, 0,      0,      0},
        '{ROW_VEC,       -32768, -32768, -32768, 0,      0,      0,      0},
        '{ROW_VEC,        32767,      0, -32768, 0,      0,      0,      0},
        '{ROW_VEC,            0,      0,      0, 0,      0,      0,      0},
        '{ROW_ROT,       -32768,  32767,      0, -1,     0,      0,      0},
        '{ROW_VEC,        32767,  32767, -32768, 0,      0,      0,      0},
        '{ROW_VEC,           -1,     -1,     -1, 0,      0,      0,      0},
        // half turn about x, with the sign of r flipped
        '{ROW_ROT,            0, -16384,      0, 0,      0,      0,      0},
        '{ROW_VEC,        16384,  16384,  16384, 0,      0,      0,      0},
        '{ROW_VEC,        -1000,   2000,  -3000, 0,      0,      0,      0}
    };

    int corner_vals [6] = '{-32768, -16384, -1, 0, 16384, 32767};

    // DUT signals; every input starts at a known value.
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [W-1:0]       i_vec_x = '0;
    logic [W-1:0]       i_vec_y = '0;
    logic [W-1:0]       i_vec_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [W-1:0]       o_out_x;
    logic [W-1:0]       o_out_y;
    logic [W-1:0]       o_out_z;

    // Local copy of the rotation registers, indexed like the register map.
    logic [W-1:0] rot_q [4] = '{16'd16384, 16'd0, 16'd0, 16'd0};

    t_vec3 rotated_pending [$];

    int  fail_count    = 0;
    int  words_in      = 0;
    int  words_out     = 0;
    int  rot_settings  = 0;
    int  idle_cycles   = 0;
    bit  gaps_on       = 1'b1;
    bit  hold_request  = 1'b0;
    bit  hold_taken    = 1'b0;
    int  hold_left     = 0;

    quaternion_vector_rotation #(
        .COMPONENT_WIDTH(W),
        .FRACTION_BITS  (FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_vec_x (i_vec_x),
        .i_vec_y (i_vec_y),
        .i_vec_z (i_vec_z),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out_x (o_out_x),
        .o_out_y (o_out_y),
        .o_out_z (o_out_z)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Round an exact sum of products to nearest (half up), then clamp to bits.
    function automatic longint round_clamp(longint acc, int bits);
        longint t;
        longint lim;
        t   = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
        lim = longint'(1) <<< (bits - 1);
        if (t > lim - 1) return lim - 1;
        if (t < -lim) return -lim;
        return t;
    endfunction

    // r * (0, v) * conj(r), vector part only.
    function automatic t_vec3 rotate_vec(t_vec3 v);
        longint x, y, z, rr, ri, rj, rk;
        longint pr, pi, pj, pk;
        t_vec3  q;
        x  = longint'(signed'(v.x));
        y  = longint'(signed'(v.y));
        z  = longint'(signed'(v.z));
        rr = longint'(signed'(rot_q[REG_ROT_REAL]));
        ri = longint'(signed'(rot_q[REG_ROT_I]));
        rj = longint'(signed'(rot_q[REG_ROT_J]));
        rk = longint'(signed'(rot_q[REG_ROT_K]));
        // first product keeps two extra integer bits
        pr = round_clamp(-(ri * x) - rj * y - rk * z, W + 2);
        pi = round_clamp(rr * x + rj * z - rk * y, W + 2);
        pj = round_clamp(rr * y - ri * z + rk * x, W + 2);
        pk = round_clamp(rr * z + ri * y - rj * x, W + 2);
        // second product against the conjugate, clamped to the component range
        q.x = W'(round_clamp(-(pr * ri) + pi * rr - pj * rk + pk * rj, W));
        q.y = W'(round_clamp(-(pr * rj) + pi * rk + pj * rr - pk * ri, W));
        q.z = W'(round_clamp(-(pr * rk) - pi * rj + pj * ri + pk * rr, W));
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one vector word, hold it until taken, then queue its expected rotation.
    task automatic send_vec(input t_vec3 v, input bit typed, input t_vec3 typed_result);
        while (gaps_on && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_vec_x <= v.x;
        i_vec_y <= v.y;
        i_vec_z <= v.z;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        rotated_pending.push_back(typed ? typed_result : rotate_vec(v));
        words_in++;
    endtask

    // Setup and access phase of one register write; leave psel up so writes chain.
    task automatic write_rot(input t_reg_idx idx, input int value);
        logic [PDATA_W-1:0] word;
        // junk above the component width must be ignored by the block
        word         = $urandom;
        word[W-1:0]  = value[W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) << REG_LSB);
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rot_q[idx] = value[W-1:0];
    endtask

    // Drain the pipeline, then load all four rotation registers.
    task automatic set_rotation(input int rr, input int ri, input int rj, input int rk);
        i_valid <= 1'b0;
        while (rotated_pending.size() != 0) @(posedge i_clk);
        write_rot(REG_ROT_REAL, rr);
        write_rot(REG_ROT_I, ri);
        write_rot(REG_ROT_J, rj);
        write_rot(REG_ROT_K, rk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rot_settings++;
    endtask

    // Pick a rotation: near-unit from a random direction, full-range noise, or corners.
    task automatic pick_rotation(input int style);
        real a [4];
        real norm;
        int  q [4];
        case (style)
            0: begin
                do begin
                    norm = 0.0;
                    for (int n = 0; n < 4; n++) begin
                        a[n] = real'(int'($urandom_range(2000)) - 1000);
                        norm += a[n] * a[n];
                    end
                end while (norm < 10000.0);
                norm = $sqrt(norm);
                for (int n = 0; n < 4; n++) q[n] = $rtoi(a[n] / norm * 16384.0);
            end
            1: begin
                for (int n = 0; n < 4; n++) q[n] = int'($urandom_range(65535)) - 32768;
            end
            default: begin
                for (int n = 0; n < 4; n++) q[n] = corner_vals[$urandom_range(5)];
            end
        endcase
        set_rotation(q[0], q[1], q[2], q[3]);
    endtask

    // Component draw: mostly full range, some within +-1.0 per component, some corners.
    function automatic logic [W-1:0] rand_comp(int mode);
        if (mode < 60) return W'($urandom);
        if (mode < 85) return W'(int'($urandom_range(32768)) - 16384);
        return W'(corner_vals[$urandom_range(5)]);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold so the pipeline backs up
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_taken) begin
            i_stall    <= 1'b1;
            hold_left  <= HOLD_CYCLES - 1;
            hold_taken <= 1'b1;
        end else begin
            i_stall <= gaps_on && ($urandom_range(99) < 19);
        end
    end

    // ------------------------------------------------------------------
    // Output check: each rotated word against the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [W-1:0] want,
                               input logic [W-1:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s mismatch: expected %0d, got %0d", name, signed'(want),
                   signed'(got));
        end
    endtask

    always @(posedge i_clk) begin
        t_vec3 want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            words_out++;
            if (rotated_pending.size() == 0) begin
                fail_count++;
                $error("rotated word with no vector pending: %0d %0d %0d",
                       signed'(o_out_x), signed'(o_out_y), signed'(o_out_z));
            end else begin
                want = rotated_pending.pop_front();
                check_field("out_x", want.x, o_out_x);
                check_field("out_y", want.y, o_out_y);
                check_field("out_z", want.z, o_out_z);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up when no word moves on either side for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a word moving", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin : sequencer
        t_vec3 v;
        t_vec3 known;
        int    mode;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: rotations at the extremes and hand-picked vectors.
        foreach (dir_rows[n]) begin
            v.x     = dir_rows[n].a[W-1:0];
            v.y     = dir_rows[n].b[W-1:0];
            v.z     = dir_rows[n].c[W-1:0];
            known.x = dir_rows[n].ex[W-1:0];
            known.y = dir_rows[n].ey[W-1:0];
            known.z = dir_rows[n].ez[W-1:0];
            case (dir_rows[n].kind)
                ROW_ROT:       set_rotation(dir_rows[n].a, dir_rows[n].b, dir_rows[n].c,
                                            dir_rows[n].d);
                ROW_VEC:       send_vec(v, 1'b0, v);
                ROW_VEC_KNOWN: send_vec(v, 1'b1, known);
                default:       ;
            endcase
        end

        // Random phases. The first runs with no gaps on either side and carries the
        // long receiver hold, so the block fills and stalls its input.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            pick_rotation(ph % 3);
            gaps_on = (ph != 0);
            if (ph == 0) hold_request = 1'b1;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                mode = $urandom_range(99);
                v.x  = rand_comp(mode);
                v.y  = rand_comp(mode);
                v.z  = rand_comp(mode);
                send_vec(v, 1'b0, v);
            end
        end

        // Drop valid, drain, then allow time for stray output words.
        i_valid <= 1'b0;
        gaps_on = 1'b1;
        while (rotated_pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Rotated %0d vectors (%0d words back) over %0d rotation settings.",
                 words_in, words_out, rot_settings);
        $display("Mismatches and unexpected words: %0d.", fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
